@@ design/obst_pkg.sv @@
package obst_pkg;

   // Field widths fixed by the interface.
   localparam int IDX_W  = 4;
   localparam int FREQ_W = 16;
   localparam int COST_W = 23;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FREQ_W-1:0] freq_type;
   typedef logic [COST_W-1:0] cost_type;

   // One command to the root search unit, issued alongside a table read.
   typedef struct packed {
      logic    clear;
      logic    valid;
      logic    left_zero;
      logic    right_zero;
      idx_type root;
   } cmp_cmd_type;

endpackage

@@ design/obst_ram.sv @@
module obst_ram #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/obst_min_unit.sv @@
module obst_min_unit
   import obst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmp_cmd_type cmd,
   input  cost_type    left_cost,
   input  cost_type    right_cost,
   output cost_type    best_cost,
   output idx_type     best_root
);

   logic     have_ff, have_in;
   cost_type best_ff, best_in;
   idx_type  root_ff, root_in;
   cost_type left_term;
   cost_type right_term;
   cost_type cand_sum;

   // An empty subrange contributes nothing.
   assign left_term  = cmd.left_zero  ? '0 : left_cost;
   assign right_term = cmd.right_zero ? '0 : right_cost;
   assign cand_sum   = COST_W'(left_term + right_term);

   // Strict compare keeps the lowest root on a tie.
   always_comb begin
      have_in = have_ff;
      best_in = best_ff;
      root_in = root_ff;
      if (cmd.clear) begin
         have_in = 1'b0;
      end else if (cmd.valid && (!have_ff || cand_sum < best_ff)) begin
         have_in = 1'b1;
         best_in = cand_sum;
         root_in = cmd.root;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      root_ff <= root_in;
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   assign best_cost = best_ff;
   assign best_root = root_ff;

endmodule

@@ design/optimal_bst_cost_table_unit.sv @@
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  req_frequency, req_final_weight
// rsp      out        rsp_valid/rsp_stall  rsp_range_start, rsp_range_end, rsp_best_root,
//                                          rsp_range_cost, rsp_end_of_run
//
// Loading takes one cycle per key word; a word with the final flag starts the solve.
// Solve writes the diagonal, then for each longer range scans every root and writes the best,
// since the one shared add-and-compare unit looks at one root candidate per cycle.
// Each result is then read from the tables, registered and held while rsp_stall is high.
// req_stall is high from the final word until the last result is taken.
// Reset is synchronous; the tables need no clearing, as an empty side's unwritten entry is masked.
module optimal_bst_cost_table_unit
   import obst_pkg::*;
#(
   parameter int MAX_KEYS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FREQ_W-1:0]   req_frequency,
   input  logic                req_final_weight,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [IDX_W-1:0]    rsp_range_start,
   output logic [IDX_W-1:0]    rsp_range_end,
   output logic [IDX_W-1:0]    rsp_best_root,
   output logic [COST_W-1:0]   rsp_range_cost,
   output logic                rsp_end_of_run
);

   localparam int TAB_DEPTH = MAX_KEYS * MAX_KEYS;
   localparam int ADDR_W    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
   localparam int WI_W      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIAG,
      S_RANGE_START,
      S_SCAN,
      S_DRAIN,
      S_WRITE,
      S_EMIT_READ,
      S_EMIT_LOAD,
      S_EMIT_HOLD
   } state_type;

   function automatic addr_type tab_addr(idx_type row, idx_type col);
      tab_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_KEYS) + ADDR_W'(col));
   endfunction

   state_type   state_ff, state_in;
   idx_type     key_count_ff, key_count_in;
   idx_type     n_ff, n_in;
   idx_type     len_ff, len_in;
   idx_type     i_ff, i_in;
   idx_type     j_ff, j_in;
   idx_type     r_ff, r_in;
   cost_type    total_ff, total_in;
   freq_type    weight_ff [0:MAX_KEYS-1];
   freq_type    weight_in [0:MAX_KEYS-1];
   cmp_cmd_type cmd_ff, cmd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   idx_type     rsp_start_ff, rsp_start_in;
   idx_type     rsp_end_ff, rsp_end_in;
   idx_type     rsp_root_ff, rsp_root_in;
   cost_type    rsp_cost_ff, rsp_cost_in;
   logic        rsp_eor_ff, rsp_eor_in;

   freq_type    weight_rd;
   logic        req_accept;
   logic        tab_we;
   addr_type    tab_wr_addr;
   cost_type    tab_wr_cost;
   idx_type     tab_wr_root;
   addr_type    left_addr;
   addr_type    right_addr;
   addr_type    cur_addr;
   cost_type    left_rd;
   cost_type    right_rd;
   idx_type     root_rd;
   cost_type    best_cost;
   idx_type     best_root;
   idx_type     last_idx;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign weight_rd  = weight_ff[r_ff[WI_W-1:0]];
   assign last_idx   = n_ff - IDX_W'(1);
   assign cur_addr   = tab_addr(i_ff, j_ff);

   // Reads for candidate root r: cost of [i..r-1] and of [r+1..j]. An empty side reads the
   // current range's own entry, not yet written, and is masked in the search unit.
   assign left_addr  = (state_ff == S_SCAN && r_ff != i_ff) ?
                       tab_addr(i_ff, r_ff - IDX_W'(1)) : cur_addr;
   assign right_addr = (state_ff == S_SCAN && r_ff != j_ff) ?
                       tab_addr(r_ff + IDX_W'(1), j_ff) : cur_addr;

   always_comb begin
      state_in     = state_ff;
      key_count_in = key_count_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      total_in     = total_ff;
      weight_in    = weight_ff;
      cmd_in       = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_eor_in   = rsp_eor_ff;
      tab_we       = 1'b0;
      tab_wr_addr  = cur_addr;
      tab_wr_cost  = COST_W'(best_cost + total_ff);
      tab_wr_root  = best_root;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (key_count_ff < IDX_W'(MAX_KEYS)) begin
                  weight_in[key_count_ff[WI_W-1:0]] = req_frequency;
                  key_count_in = key_count_ff + IDX_W'(1);
               end
               if (req_final_weight) begin
                  n_in     = key_count_in;
                  r_in     = '0;
                  state_in = S_DIAG;
               end
            end
         end
         S_DIAG: begin
            tab_we      = 1'b1;
            tab_wr_addr = tab_addr(r_ff, r_ff);
            tab_wr_cost = COST_W'(weight_rd);
            tab_wr_root = r_ff;
            if (r_ff == last_idx) begin
               if (n_ff == IDX_W'(1)) begin
                  i_in     = '0;
                  j_in     = '0;
                  state_in = S_EMIT_READ;
               end else begin
                  len_in   = IDX_W'(2);
                  i_in     = '0;
                  j_in     = IDX_W'(1);
                  state_in = S_RANGE_START;
               end
            end else begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         S_RANGE_START: begin
            r_in         = i_ff;
            total_in     = '0;
            cmd_in.clear = 1'b1;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            total_in          = COST_W'(total_ff + COST_W'(weight_rd));
            cmd_in.valid      = 1'b1;
            cmd_in.left_zero  = (r_ff == i_ff);
            cmd_in.right_zero = (r_ff == j_ff);
            cmd_in.root       = r_ff;
            if (r_ff == j_ff) begin
               state_in = S_DRAIN;
            end else begin
               r_in = r_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            tab_we = 1'b1;
            if (j_ff == last_idx) begin
               if (len_ff == n_ff) begin
                  i_in     = last_idx;
                  j_in     = last_idx;
                  state_in = S_EMIT_READ;
               end else begin
                  len_in   = len_ff + IDX_W'(1);
                  i_in     = '0;
                  j_in     = len_ff;
                  state_in = S_RANGE_START;
               end
            end else begin
               i_in     = i_ff + IDX_W'(1);
               j_in     = j_ff + IDX_W'(1);
               state_in = S_RANGE_START;
            end
         end
         S_EMIT_READ: begin
            state_in = S_EMIT_LOAD;
         end
         S_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_start_in = i_ff;
            rsp_end_in   = j_ff;
            rsp_root_in  = root_rd;
            rsp_cost_in  = left_rd;
            rsp_eor_in   = (i_ff == '0) && (j_ff == last_idx);
            state_in     = S_EMIT_HOLD;
         end
         S_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_EMIT_READ;
               if (j_ff == last_idx) begin
                  if (i_ff == '0) begin
                     key_count_in = '0;
                     state_in     = S_IDLE;
                  end else begin
                     i_in = i_ff - IDX_W'(1);
                     j_in = i_ff - IDX_W'(1);
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      len_ff       <= len_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      r_ff         <= r_in;
      total_ff     <= total_in;
      weight_ff    <= weight_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_eor_ff   <= rsp_eor_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         key_count_ff <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The cost table is kept twice so both subrange costs are read in the same cycle.
   obst_ram #(
      .WIDTH (COST_W),
      .DEPTH (TAB_DEPTH)
   ) u_cost_left_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_cost),
      .rd_addr (left_addr),
      .rd_data (left_rd)
   );

   obst_ram #(
      .WIDTH (COST_W),
      .DEPTH (TAB_DEPTH)
   ) u_cost_right_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_cost),
      .rd_addr (right_addr),
      .rd_data (right_rd)
   );

   obst_ram #(
      .WIDTH (IDX_W),
      .DEPTH (TAB_DEPTH)
   ) u_root_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_root),
      .rd_addr (cur_addr),
      .rd_data (root_rd)
   );

   obst_min_unit u_min_unit (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd_ff),
      .left_cost  (left_rd),
      .right_cost (right_rd),
      .best_cost  (best_cost),
      .best_root  (best_root)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_start = rsp_start_ff;
   assign rsp_range_end   = rsp_end_ff;
   assign rsp_best_root   = rsp_root_ff;
   assign rsp_range_cost  = rsp_cost_ff;
   assign rsp_end_of_run  = rsp_eor_ff;

   a_key_count_bound: assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= IDX_W'(MAX_KEYS))
      else $error("key count beyond table size");

   a_scan_root_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (r_ff >= i_ff) && (r_ff <= j_ff) && (j_ff < n_ff))
      else $error("candidate root outside its range");

   a_result_well_formed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_start_ff <= rsp_end_ff) && (rsp_end_ff < n_ff)
                       && (rsp_root_ff >= rsp_start_ff) && (rsp_root_ff <= rsp_end_ff))
      else $error("result range or root malformed");

   a_end_covers_all: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_eor_ff |-> (rsp_start_ff == '0) && (rsp_end_ff == last_idx))
      else $error("end of run on a partial range");

   a_no_write_while_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_READ || state_ff == S_EMIT_LOAD || state_ff == S_EMIT_HOLD)
      |-> !tab_we)
      else $error("table written during output");

endmodule
